@@ rtl/rtcc_pkg.sv @@
`timescale 1ns / 1ps

package rtcc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_YEAR   = 3'd0;
  localparam logic [2:0] CFG_MONTH  = 3'd1;
  localparam logic [2:0] CFG_DAY    = 3'd2;
  localparam logic [2:0] CFG_HOUR   = 3'd3;
  localparam logic [2:0] CFG_MINUTE = 3'd4;
  localparam logic [2:0] CFG_SECOND = 3'd5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  typedef logic [2:0] op_t;

  // operations run on the shared multiplier, in sequence order
  localparam op_t OP_Y25    = 3'd0;  // base year mod 25
  localparam op_t OP_F125   = 3'd1;  // fine * 8 / 1000 = fine / 125
  localparam op_t OP_C524   = 3'd2;  // coarse * 524, low word
  localparam op_t OP_MS1000 = 3'd3;  // milliseconds to seconds
  localparam op_t OP_S60    = 3'd4;  // seconds to minutes
  localparam op_t OP_M60    = 3'd5;  // minutes to hours
  localparam op_t OP_H24    = 3'd6;  // hours to days

  typedef struct packed {
    logic mul;
    logic est;
    op_t  op;
  } mdu_ctl_t;

  typedef struct packed {
    logic [13:0] yr;
    logic [3:0]  mon;
    logic [6:0]  day;
    logic [4:0]  m25;  // year mod 25, tracked along with yr
  } cal_t;

  // floor(2^32 / divisor); for the plain product, the factor itself
  function automatic logic [27:0] op_mult(input op_t op);
    logic [27:0] m;
    case (op)
      OP_Y25:    m = 28'd171798691;
      OP_F125:   m = 28'd34359738;
      OP_C524:   m = 28'd524;
      OP_MS1000: m = 28'd4294967;
      OP_S60:    m = 28'd71582788;
      OP_M60:    m = 28'd71582788;
      OP_H24:    m = 28'd178956970;
      default:   m = 28'd0;
    endcase
    return m;
  endfunction

  function automatic logic [9:0] op_div(input op_t op);
    logic [9:0] d;
    case (op)
      OP_Y25:    d = 10'd25;
      OP_F125:   d = 10'd125;
      OP_MS1000: d = 10'd1000;
      OP_S60:    d = 10'd60;
      OP_M60:    d = 10'd60;
      OP_H24:    d = 10'd24;
      default:   d = 10'd1;
    endcase
    return d;
  endfunction

  // month length; months outside 1..12 count as 31 days
  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] n;
    case (mon)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/rtcc_in_if.sv @@
`timescale 1ns / 1ps

interface rtcc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] coarse_count;
  logic [15:0] fine_count;

  modport source (output valid, output coarse_count, output fine_count, input ready);
  modport sink (input valid, input coarse_count, input fine_count, output ready);
endinterface

@@ rtl/rtcc_out_if.sv @@
`timescale 1ns / 1ps

interface rtcc_out_if;
  logic        valid;
  logic        ready;
  logic [22:0] elapsed_seconds;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  modport source (
    output valid, output elapsed_seconds, output out_year, output out_month,
    output out_day, output out_hour, output out_minute, output out_second,
    input ready
  );
  modport sink (
    input valid, input elapsed_seconds, input out_year, input out_month,
    input out_day, input out_hour, input out_minute, input out_second,
    output ready
  );
endinterface

@@ rtl/rtcc_mdu.sv @@
`timescale 1ns / 1ps

// Shared multiplier: plain product, or division by a constant through the
// reciprocal. The estimate is at most one low, so one compare fixes it.
module rtcc_mdu (
  input  logic              clk_i,
  input  rtcc_pkg::mdu_ctl_t ctl_i,
  input  logic [31:0]       x_i,
  output logic [31:0]       prod_lo_o,
  output logic [27:0]       q_o,
  output logic [10:0]       r_o
);

  logic [27:0] mult;
  logic [9:0]  dvsr;
  logic [59:0] prod_d;
  logic [59:0] prod_q;
  logic [31:0] xk_q;
  logic [31:0] qd;
  logic [31:0] rem_full;
  logic [27:0] qe_q;
  logic [10:0] re_q;
  logic        ge;

  assign mult   = rtcc_pkg::op_mult(ctl_i.op);
  assign dvsr   = rtcc_pkg::op_div(ctl_i.op);
  assign prod_d = {28'd0, x_i} * {32'd0, mult};

  // only the low word matters: the true remainder is below 2048
  assign qd       = {4'd0, prod_q[59:32]} * {22'd0, dvsr};
  assign rem_full = xk_q - qd;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= prod_d;
      xk_q   <= x_i;
    end
    if (ctl_i.est) begin
      qe_q <= prod_q[59:32];
      re_q <= rem_full[10:0];
    end
  end

  assign ge        = (re_q >= {1'b0, dvsr});
  assign q_o       = ge ? qe_q + 28'd1 : qe_q;
  assign r_o       = ge ? re_q - {1'b0, dvsr} : re_q;
  assign prod_lo_o = prod_q[31:0];

endmodule

@@ rtl/rtcc_roll.sv @@
`timescale 1ns / 1ps

// One month rollover step of the calendar.
module rtcc_roll (
  input  rtcc_pkg::cal_t cal_i,
  output logic           over_o,
  output rtcc_pkg::cal_t cal_o
);

  logic       leap;
  logic [4:0] mdays;

  // divisible by 100 means divisible by 4 and by 25; by 400 means by 16 and by 25
  assign leap  = (cal_i.yr[1:0] == 2'd0) && ((cal_i.m25 != 5'd0) || (cal_i.yr[3:0] == 4'd0));
  assign mdays = rtcc_pkg::month_days(cal_i.mon, leap);
  assign over_o = (cal_i.day > {2'b00, mdays});

  always_comb begin
    cal_o     = cal_i;
    cal_o.day = cal_i.day - {2'b00, mdays};
    if (cal_i.mon >= 4'd12) begin
      cal_o.mon = 4'd1;
      cal_o.yr  = cal_i.yr + 14'd1;
      if (cal_i.yr == 14'h3FFF || cal_i.m25 == 5'd24) begin
        cal_o.m25 = 5'd0;
      end else begin
        cal_o.m25 = cal_i.m25 + 5'd1;
      end
    end else begin
      cal_o.mon = cal_i.mon + 4'd1;
    end
  end

endmodule

@@ rtl/rtc_count_to_calendar_core.sv @@
`timescale 1ns / 1ps

// The sequencer runs seven operations on one shared multiplier, then steps
// the month rollover until the day fits, and loads the result once the output
// register is free. A new item is taken only when idle, after that load.
// Reset: base date-time returns to 2021-01-01 00:00:00, sequencer idle,
// no result pending.
module rtc_count_to_calendar_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rtcc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rtcc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  rtcc_in_if.sink                           in_i,
  rtcc_out_if.source                        out_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_EST  = 3'd2;
  localparam logic [2:0] ST_TAKE = 3'd3;
  localparam logic [2:0] ST_ROLL = 3'd4;

  logic [2:0]  state_q, state_d;
  rtcc_pkg::op_t op_q;

  logic [13:0] base_year_q;
  logic [3:0]  base_month_q;
  logic [4:0]  base_day_q;
  logic [4:0]  base_hour_q;
  logic [5:0]  base_minute_q;
  logic [5:0]  base_second_q;

  logic [31:0] coarse_q;
  logic [15:0] fine_q;
  logic [9:0]  fq_q;
  logic [31:0] x_q;
  logic [22:0] elapsed_q;
  logic [5:0]  sec_q;
  logic [5:0]  min_q;
  logic [4:0]  hr_q;
  rtcc_pkg::cal_t cal_q;
  rtcc_pkg::cal_t cal_nxt;
  logic        over;

  rtcc_pkg::mdu_ctl_t ctl;
  logic [31:0] prod_lo;
  logic [27:0] q;
  logic [10:0] r;

  logic        out_valid_q;
  logic        out_load;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q   <= 14'd2021;
      base_month_q  <= 4'd1;
      base_day_q    <= 5'd1;
      base_hour_q   <= 5'd0;
      base_minute_q <= 6'd0;
      base_second_q <= 6'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rtcc_pkg::CFG_YEAR:   base_year_q   <= cfg_wdata_i;
        rtcc_pkg::CFG_MONTH:  base_month_q  <= cfg_wdata_i[3:0];
        rtcc_pkg::CFG_DAY:    base_day_q    <= cfg_wdata_i[4:0];
        rtcc_pkg::CFG_HOUR:   base_hour_q   <= cfg_wdata_i[4:0];
        rtcc_pkg::CFG_MINUTE: base_minute_q <= cfg_wdata_i[5:0];
        rtcc_pkg::CFG_SECOND: base_second_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  assign ctl.mul = (state_q == ST_MUL);
  assign ctl.est = (state_q == ST_EST);
  assign ctl.op  = op_q;

  rtcc_mdu u_mdu (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .x_i       (x_q),
    .prod_lo_o (prod_lo),
    .q_o       (q),
    .r_o       (r)
  );

  rtcc_roll u_roll (
    .cal_i  (cal_q),
    .over_o (over),
    .cal_o  (cal_nxt)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_ROLL) && !over && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_MUL;
      ST_MUL:  state_d = (op_q == rtcc_pkg::OP_C524) ? ST_TAKE : ST_EST;
      ST_EST:  state_d = ST_TAKE;
      ST_TAKE: state_d = (op_q == rtcc_pkg::OP_H24) ? ST_ROLL : ST_MUL;
      ST_ROLL: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= rtcc_pkg::OP_Y25;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_IDLE && in_i.valid) begin
        op_q <= rtcc_pkg::OP_Y25;
      end else if (state_q == ST_TAKE) begin
        case (op_q)
          rtcc_pkg::OP_Y25:    op_q <= rtcc_pkg::OP_F125;
          rtcc_pkg::OP_F125:   op_q <= rtcc_pkg::OP_C524;
          rtcc_pkg::OP_C524:   op_q <= rtcc_pkg::OP_MS1000;
          rtcc_pkg::OP_MS1000: op_q <= rtcc_pkg::OP_S60;
          rtcc_pkg::OP_S60:    op_q <= rtcc_pkg::OP_M60;
          rtcc_pkg::OP_M60:    op_q <= rtcc_pkg::OP_H24;
          default:             op_q <= rtcc_pkg::OP_Y25;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      coarse_q <= in_i.coarse_count;
      fine_q   <= in_i.fine_count;
      x_q      <= {18'd0, base_year_q};
    end
    if (state_q == ST_TAKE) begin
      case (op_q)
        rtcc_pkg::OP_Y25: begin
          cal_q.m25 <= r[4:0];
          x_q       <= {16'd0, fine_q};
        end
        rtcc_pkg::OP_F125: begin
          fq_q <= q[9:0];
          x_q  <= coarse_q;
        end
        rtcc_pkg::OP_C524: begin
          x_q <= prod_lo + {22'd0, fq_q};  // wraps at 32 bits
        end
        rtcc_pkg::OP_MS1000: begin
          elapsed_q <= q[22:0];
          x_q       <= {9'd0, q[22:0]} + {26'd0, base_second_q};
        end
        rtcc_pkg::OP_S60: begin
          sec_q <= r[5:0];
          x_q   <= {15'd0, q[16:0]} + {26'd0, base_minute_q};
        end
        rtcc_pkg::OP_M60: begin
          min_q <= r[5:0];
          x_q   <= {21'd0, q[10:0]} + {27'd0, base_hour_q};
        end
        rtcc_pkg::OP_H24: begin
          hr_q       <= r[4:0];
          cal_q.yr   <= base_year_q;
          cal_q.mon  <= base_month_q;
          cal_q.day  <= {1'b0, q[5:0]} + {2'b00, base_day_q};
        end
        default: ;
      endcase
    end
    // advance one month per cycle until the day fits
    if (state_q == ST_ROLL && over) begin
      cal_q <= cal_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.elapsed_seconds <= elapsed_q;
      out_o.out_year        <= cal_q.yr;
      out_o.out_month       <= cal_q.mon;
      out_o.out_day         <= cal_q.day[4:0];
      out_o.out_hour        <= hr_q;
      out_o.out_minute      <= min_q;
      out_o.out_second      <= sec_q;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

@@ tb/rtc_count_to_calendar_core_test.sv @@
`timescale 1ns / 1ps

module rtc_count_to_calendar_core_test;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned PHASE_ITEMS = 90;
  localparam int unsigned PHASE_COUNT = 13;
  // index with no register behind it
  localparam logic [2:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic [22:0] elapsed;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  class calendar_scoreboard;
    int unsigned base_year = 2021;
    int unsigned base_month = 1;
    int unsigned base_day = 1;
    int unsigned base_hour = 0;
    int unsigned base_minute = 0;
    int unsigned base_second = 0;
    calendar_t due_stamps[$];
    int errors = 0;

    function void set_base(logic [2:0] idx, logic [13:0] data);
      case (idx)
        rtcc_pkg::CFG_YEAR:   base_year = 32'(data);
        rtcc_pkg::CFG_MONTH:  base_month = 32'(data[3:0]);
        rtcc_pkg::CFG_DAY:    base_day = 32'(data[4:0]);
        rtcc_pkg::CFG_HOUR:   base_hour = 32'(data[4:0]);
        rtcc_pkg::CFG_MINUTE: base_minute = 32'(data[5:0]);
        rtcc_pkg::CFG_SECOND: base_second = 32'(data[5:0]);
        default: ;
      endcase
    endfunction

    function bit is_leap(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function int unsigned days_in(int unsigned y, int unsigned mo);
      case (mo)
        2:             return is_leap(y) ? 29 : 28;
        4, 6, 9, 11:   return 30;
        default:       return 31;
      endcase
    endfunction

    // work out the calendar stamp for one accepted counter pair
    function void note_request(logic [31:0] coarse, logic [15:0] fine);
      logic [63:0] ms_wide;
      int unsigned elapsed, s, m, h, d, mo, y;
      calendar_t stamp;
      ms_wide = {32'd0, coarse} * 64'd524 + ({48'd0, fine} * 64'd8) / 64'd1000;
      elapsed = ms_wide[31:0] / 1000;
      s = base_second + elapsed;
      m = base_minute + s / 60;
      s = s % 60;
      h = base_hour + m / 60;
      m = m % 60;
      d = base_day + h / 24;
      h = h % 24;
      mo = base_month;
      y = base_year;
      while (d > days_in(y, mo)) begin
        d = d - days_in(y, mo);
        mo = mo + 1;
        if (mo > 12) begin
          mo = 1;
          y = (y + 1) & 32'h3FFF;
        end
      end
      stamp.elapsed = 23'(elapsed);
      stamp.year = 14'(y);
      stamp.month = 4'(mo);
      stamp.day = 5'(d);
      stamp.hour = 5'(h);
      stamp.minute = 6'(m);
      stamp.second = 6'(s);
      due_stamps.push_back(stamp);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task check_stamp(calendar_t got);
      calendar_t want;
      if (due_stamps.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      want = due_stamps.pop_front();
      check_field("elapsed_seconds", 32'(got.elapsed), 32'(want.elapsed));
      check_field("out_year", 32'(got.year), 32'(want.year));
      check_field("out_month", 32'(got.month), 32'(want.month));
      check_field("out_day", 32'(got.day), 32'(want.day));
      check_field("out_hour", 32'(got.hour), 32'(want.hour));
      check_field("out_minute", 32'(got.minute), 32'(want.minute));
      check_field("out_second", 32'(got.second), 32'(want.second));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [rtcc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [rtcc_pkg::CfgDataW-1:0] cfg_wdata_i;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int unsigned cycle_count = 0;

  calendar_scoreboard sb = new();

  rtcc_in_if req_if ();
  rtcc_out_if stamp_if ();

  rtc_count_to_calendar_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (stamp_if)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rtc_count_to_calendar_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && stamp_if.valid && stamp_if.ready)
      sb.check_stamp({stamp_if.elapsed_seconds, stamp_if.out_year, stamp_if.out_month,
                      stamp_if.out_day, stamp_if.out_hour, stamp_if.out_minute,
                      stamp_if.out_second});
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    stamp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        stamp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        stamp_if.ready <= !idle_en || ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send_request(input logic [31:0] coarse, input logic [15:0] fine);
    if (idle_en) begin
      while ($urandom_range(99) < 33) begin
        req_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    req_if.valid <= 1'b1;
    req_if.coarse_count <= coarse;
    req_if.fine_count <= fine;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(coarse, fine);
    @(negedge clk_i);
  endtask

  task automatic stop_requests();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.due_stamps.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [13:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    sb.set_base(idx, data);
    @(negedge clk_i);
  endtask

  task automatic write_base(input logic [13:0] year, input logic [13:0] month,
                            input logic [13:0] day, input logic [13:0] hour,
                            input logic [13:0] minute, input logic [13:0] second);
    write_reg(rtcc_pkg::CFG_YEAR, year);
    write_reg(rtcc_pkg::CFG_MONTH, month);
    write_reg(rtcc_pkg::CFG_DAY, day);
    write_reg(rtcc_pkg::CFG_HOUR, hour);
    write_reg(rtcc_pkg::CFG_MINUTE, minute);
    write_reg(rtcc_pkg::CFG_SECOND, second);
    write_reg(CFG_SPARE, 14'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // set stray bits above the field width now and then
  function automatic logic [13:0] with_noise(input logic [13:0] v, input int w);
    logic [13:0] n;
    n = 14'($urandom);
    n = n << w;
    return ($urandom_range(1) == 0) ? v : (v | n);
  endfunction

  task automatic random_base();
    logic [13:0] y, mo, d, h, mi, s;
    case ($urandom_range(3))
      0:       y = 14'($urandom_range(16383));
      1:       y = 14'(100 * $urandom_range(163));
      2:       y = 14'(2000 + $urandom_range(99));
      default: y = 14'($urandom_range(9999));
    endcase
    mo = 14'(($urandom_range(99) < 80) ? $urandom_range(12, 1) : $urandom_range(15));
    d = 14'(($urandom_range(99) < 85) ? $urandom_range(31, 1) : $urandom_range(31));
    h = 14'(($urandom_range(99) < 80) ? $urandom_range(23) : $urandom_range(31));
    mi = 14'(($urandom_range(99) < 80) ? $urandom_range(59) : $urandom_range(63));
    s = 14'(($urandom_range(99) < 80) ? $urandom_range(59) : $urandom_range(63));
    write_base(y, with_noise(mo, 4), with_noise(d, 5), with_noise(h, 5),
               with_noise(mi, 6), with_noise(s, 6));
  endtask

  function automatic logic [31:0] pick_coarse();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(8196602);
      2:       return $urandom_range(8196620, 8196590);
      default: return $urandom_range(400000);
    endcase
  endfunction

  task automatic run_random_phase(input int hold_at, input int pause_at);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) begin
        stop_requests();
        wait_drained();
      end
      send_request(pick_coarse(), 16'($urandom_range(65535)));
    end
    stop_requests();
    wait_drained();
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.coarse_count = '0;
    req_if.fine_count = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset base: field extremes, millisecond wrap, one-second boundary
    send_request(32'd0, 16'd0);
    send_request(32'd0, 16'hFFFF);
    send_request(32'hFFFF_FFFF, 16'hFFFF);
    send_request(32'hFFFF_FFFF, 16'd0);
    send_request(32'd8196602, 16'hFFFF);
    send_request(32'd8196603, 16'd0);
    send_request(32'd1, 16'd59499);
    send_request(32'd1, 16'd59500);
    send_request(32'hAAAA_AAAA, 16'h5555);
    send_request(32'h5555_5555, 16'hAAAA);
    stop_requests();
    wait_drained();

    // year counter wraps past its top
    write_base(14'd16383, 14'd12, 14'd31, 14'd23, 14'd59, 14'd59);
    send_request(32'd2, 16'd0);
    send_request(32'd164886, 16'd0);
    stop_requests();
    wait_drained();

    // leap by the 400 rule, then a century that is not leap
    write_base(14'd2000, 14'd2, 14'd28, 14'd23, 14'd59, 14'd59);
    send_request(32'd2, 16'd0);
    send_request(32'd164886, 16'd0);
    stop_requests();
    wait_drained();
    write_base(14'd1900, 14'd2, 14'd28, 14'd23, 14'd59, 14'd59);
    send_request(32'd2, 16'd0);
    stop_requests();
    wait_drained();

    // month zero and base time fields past their ranges
    write_base(14'd2023, 14'd0, 14'd31, 14'd31, 14'd63, 14'd63);
    send_request(32'd0, 16'd0);
    send_request(32'hFFFF_FFFF, 16'hFFFF);
    stop_requests();
    wait_drained();

    // month above twelve, day zero
    write_base(14'd9999, 14'd15, 14'd0, 14'd0, 14'd0, 14'd0);
    send_request(32'd0, 16'd0);
    send_request(32'hFFFF_FFFF, 16'd0);
    stop_requests();
    wait_drained();
    write_base(14'd2024, 14'd13, 14'd31, 14'd23, 14'd59, 14'd59);
    send_request(32'd2, 16'd0);
    stop_requests();
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 0)
        write_base(14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
      else if (p == 1)
        write_base(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
      else
        random_base();
      idle_en = (p != 3);
      run_random_phase((p == 5) ? 10 : -1, (p == 8) ? 45 : -1);
    end
    idle_en = 1'b1;

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.errors == 0 && sb.due_stamps.size() == 0)
      $display("rtc_count_to_calendar_core regression: pass");
    else
      $display("rtc_count_to_calendar_core regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rtcc_pkg.sv
rtl/rtcc_in_if.sv
rtl/rtcc_out_if.sv
rtl/rtcc_mdu.sv
rtl/rtcc_roll.sv
rtl/rtc_count_to_calendar_core.sv
tb/rtc_count_to_calendar_core_test.sv
